[hdl/pcc_pkg.sv]
// shared constants and types for the pearson correlation column block
`default_nettype none
package pcc_pkg;
  localparam int ONE_FIXED = 16384;
  localparam int K_BITS = 15;
  localparam int CORR_BITS = 16;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NXX, ST_SX2, ST_NYY, ST_SY2, ST_CHK, ST_P, ST_Q,
    ST_RHS, ST_AB, ST_TRY, ST_ODD2, ST_LHS, ST_OUT
  } back_state_t;
endpackage
`default_nettype wire

[hdl/pearson_correlation_column.sv]
// top level: streaming pearson correlation of a column against a reference vector
// throughput: one sample pair per cycle while the two-entry snapshot queue has room
// per column the back end runs up to eight shift-add multiplies plus up to two per step of
// the 15-step root search, each stopping once its remaining multiplier bits are zero
// it takes one snapshot at a time; columns that end faster than it finishes stall the input
// synchronous active-low reset clears sums, queue, sequencer and output valid
`default_nettype none
module pearson_correlation_column #(
  parameter int MAX_PAIRS = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [SAMPLE_BITS-1:0]       in_x_sample,
  input  wire logic [SAMPLE_BITS-1:0]       in_y_sample,
  input  wire logic                         in_last_of_column,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [pcc_pkg::CORR_BITS-1:0]     out_correlation,
  output logic                              out_degenerate
);
  import pcc_pkg::*;

  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int SW = SAMPLE_BITS + CW;
  localparam int QW = 2 * SAMPLE_BITS + CW;
  localparam int DW = CW + 2 * SW + 3 * QW;

  logic          push, full, pop, qv;
  logic [DW-1:0] push_data, pop_data;

  pcc_front #(.MAX_PAIRS(MAX_PAIRS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_x_sample(in_x_sample), .in_y_sample(in_y_sample),
    .in_last_of_column(in_last_of_column), .q_full(full), .q_push(push),
    .q_data(push_data)
  );

  pcc_fifo #(.WIDTH(DW)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .valid(qv), .pop_data(pop_data)
  );

  pcc_back #(.MAX_PAIRS(MAX_PAIRS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(qv), .q_data(pop_data), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_correlation(out_correlation),
    .out_degenerate(out_degenerate)
  );
endmodule
`default_nettype wire

[hdl/pcc_front.sv]
// front end: takes sample pairs, keeps count and running sums, emits a snapshot per column
`default_nettype none
module pcc_front #(
  parameter int MAX_PAIRS = 4096,
  parameter int SAMPLE_BITS = 16,
  parameter int CW = $clog2(MAX_PAIRS + 1),
  parameter int SW = SAMPLE_BITS + CW,
  parameter int QW = 2 * SAMPLE_BITS + CW,
  parameter int DW = CW + 2 * SW + 3 * QW
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] in_x_sample,
  input  wire logic [SAMPLE_BITS-1:0] in_y_sample,
  input  wire logic                   in_last_of_column,
  input  wire logic                   q_full,
  output logic                        q_push,
  output logic [DW-1:0]               q_data
);
  localparam int SB = SAMPLE_BITS;

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [SW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [QW-1:0]        sxx_r, sxx_nxt, syy_r, syy_nxt;
  logic signed [QW-1:0] sxy_r, sxy_nxt;
  logic signed [SB-1:0] x, y;
  logic signed [2*SB-1:0] xx, yy, xy;
  logic                 take;

  assign x = in_x_sample;
  assign y = in_y_sample;
  assign xx = x * x;
  assign yy = y * y;
  assign xy = x * y;
  assign in_stall = q_full;
  assign take = in_valid && !in_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    sxx_nxt = sxx_r;
    syy_nxt = syy_r;
    sxy_nxt = sxy_r;
    if (cnt_r < CW'(MAX_PAIRS)) begin
      cnt_nxt = cnt_r + CW'(1);
      sx_nxt = sx_r + {{(SW-SB){x[SB-1]}}, x};
      sy_nxt = sy_r + {{(SW-SB){y[SB-1]}}, y};
      sxx_nxt = sxx_r + {{CW{1'b0}}, xx};
      syy_nxt = syy_r + {{CW{1'b0}}, yy};
      sxy_nxt = sxy_r + {{CW{xy[2*SB-1]}}, xy};
    end
  end

  assign q_push = take && in_last_of_column;
  assign q_data = {cnt_nxt, sx_nxt, sy_nxt, sxx_nxt, syy_nxt, sxy_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      cnt_r <= '0;
      sx_r <= '0;
      sy_r <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_nxt;
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      sxx_r <= sxx_nxt;
      syy_r <= syy_nxt;
      sxy_r <= sxy_nxt;
    end
  end
endmodule
`default_nettype wire

[hdl/pcc_fifo.sv]
// two-entry queue of column snapshots between front and back
`default_nettype none
module pcc_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic [WIDTH-1:0]      pop_data
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wr_r, rd_r;
  logic [1:0]       cnt_r;

  assign full = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= 1'b0;
      rd_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[hdl/pcc_mul.sv]
// shift-add multiplier, one multiplier bit per cycle, stops early when done
`default_nettype none
module pcc_mul #(
  parameter int PW = 64,
  parameter int BW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [PW-1:0] a_in,
  input  wire logic [BW-1:0] b_in,
  output logic               done,
  output logic [PW-1:0]      prod
);
  logic [PW-1:0] a_r, acc_r;
  logic [BW-1:0] b_r;
  logic          busy_r;

  assign done = busy_r && (b_r == '0);
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a_in;
      b_r <= b_in;
      acc_r <= '0;
    end else if (busy_r && b_r != '0) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else if (start) busy_r <= 1'b1;
    else if (done) busy_r <= 1'b0;
  end
endmodule
`default_nettype wire

[hdl/pcc_back.sv]
// back end: sequencer that turns a column snapshot into the coefficient
`default_nettype none
module pcc_back #(
  parameter int MAX_PAIRS = 4096,
  parameter int SAMPLE_BITS = 16,
  parameter int CW = $clog2(MAX_PAIRS + 1),
  parameter int SW = SAMPLE_BITS + CW,
  parameter int QW = 2 * SAMPLE_BITS + CW,
  parameter int DW = CW + 2 * SW + 3 * QW
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire logic [DW-1:0]                q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [pcc_pkg::CORR_BITS-1:0]     out_correlation,
  output logic                              out_degenerate
);
  import pcc_pkg::*;

  localparam int AW = 2 * SAMPLE_BITS + 2 * CW;
  localparam int BW = AW + K_BITS;
  localparam int PW = 2 * AW + 2 * K_BITS;
  localparam int IW = $clog2(K_BITS);

  back_state_t state_r, state_nxt;

  logic [CW-1:0]        q_n;
  logic signed [SW-1:0] q_sx, q_sy;
  logic [QW-1:0]        q_sxx, q_syy;
  logic signed [QW-1:0] q_sxy;

  logic [CW-1:0]        n_r, n_nxt;
  logic signed [SW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [QW-1:0]        sxx_r, sxx_nxt, syy_r, syy_nxt;
  logic signed [QW-1:0] sxy_r, sxy_nxt;
  logic [PW-1:0]        tmp_r, tmp_nxt, rhs_r, rhs_nxt, ab_r, ab_nxt;
  logic [AW-1:0]        spa_r, spa_nxt, spb_r, spb_nxt, mag_r, mag_nxt;
  logic                 neg_r, neg_nxt, started_r, started_nxt;
  logic [K_BITS-1:0]    k_r, k_nxt, cand;
  logic [IW-1:0]        bit_r, bit_nxt;
  logic [2*K_BITS-1:0]  odd2_r, odd2_nxt;
  logic [K_BITS:0]      odd;
  logic [CORR_BITS-1:0] corr_r, corr_nxt, res_corr_r, res_corr_nxt;
  logic                 degen_r, degen_nxt, ov_r, ov_nxt;
  logic                 res_degen_r, res_degen_nxt;

  logic [SW-1:0] abs_x, abs_y;
  logic [QW-1:0] abs_xy;
  logic signed [AW+1:0] num;

  logic          mul_start, mul_done;
  logic [PW-1:0] mul_a, mul_prod;
  logic [BW-1:0] mul_b;

  assign {q_n, q_sx, q_sy, q_sxx, q_syy, q_sxy} = q_data;

  pcc_mul #(.PW(PW), .BW(BW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a_in(mul_a), .b_in(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  assign abs_x = sx_r[SW-1] ? SW'(-sx_r) : SW'(sx_r);
  assign abs_y = sy_r[SW-1] ? SW'(-sy_r) : SW'(sy_r);
  assign abs_xy = sxy_r[QW-1] ? QW'(-sxy_r) : QW'(sxy_r);
  assign cand = k_r | (K_BITS'(1) << bit_r);
  assign odd = {cand, 1'b0} - (K_BITS+1)'(1);

  assign out_valid = ov_r;
  assign out_correlation = corr_r;
  assign out_degenerate = degen_r;

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    sxx_nxt = sxx_r;
    syy_nxt = syy_r;
    sxy_nxt = sxy_r;
    tmp_nxt = tmp_r;
    rhs_nxt = rhs_r;
    ab_nxt = ab_r;
    spa_nxt = spa_r;
    spb_nxt = spb_r;
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    k_nxt = k_r;
    bit_nxt = bit_r;
    odd2_nxt = odd2_r;
    corr_nxt = corr_r;
    degen_nxt = degen_r;
    res_corr_nxt = res_corr_r;
    res_degen_nxt = res_degen_r;
    ov_nxt = ov_r && out_stall;
    started_nxt = started_r;
    q_pop = 1'b0;
    mul_a = '0;
    mul_b = '0;
    num = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          n_nxt = q_n;
          sx_nxt = q_sx;
          sy_nxt = q_sy;
          sxx_nxt = q_sxx;
          syy_nxt = q_syy;
          sxy_nxt = q_sxy;
          state_nxt = ST_NXX;
        end
      end
      ST_NXX: begin
        mul_a = PW'(n_r);
        mul_b = BW'(sxx_r);
        if (mul_done) begin
          tmp_nxt = mul_prod;
          state_nxt = ST_SX2;
        end
      end
      ST_SX2: begin
        mul_a = PW'(abs_x);
        mul_b = BW'(abs_x);
        if (mul_done) begin
          spa_nxt = AW'(tmp_r - mul_prod);
          state_nxt = ST_NYY;
        end
      end
      ST_NYY: begin
        mul_a = PW'(n_r);
        mul_b = BW'(syy_r);
        if (mul_done) begin
          tmp_nxt = mul_prod;
          state_nxt = ST_SY2;
        end
      end
      ST_SY2: begin
        mul_a = PW'(abs_y);
        mul_b = BW'(abs_y);
        if (mul_done) begin
          spb_nxt = AW'(tmp_r - mul_prod);
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (spa_r == '0 || spb_r == '0) begin
          res_corr_nxt = '0;
          res_degen_nxt = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          res_degen_nxt = 1'b0;
          state_nxt = ST_P;
        end
      end
      ST_P: begin
        mul_a = PW'(n_r);
        mul_b = BW'(abs_xy);
        if (mul_done) begin
          tmp_nxt = mul_prod;
          state_nxt = ST_Q;
        end
      end
      ST_Q: begin
        mul_a = PW'(abs_x);
        mul_b = BW'(abs_y);
        num = (sxy_r[QW-1] ? -$signed((AW+2)'(tmp_r)) : $signed((AW+2)'(tmp_r)))
            - (((sx_r[SW-1] ^ sy_r[SW-1])) ? -$signed((AW+2)'(mul_prod))
                                            : $signed((AW+2)'(mul_prod)));
        if (mul_done) begin
          neg_nxt = num[AW+1];
          mag_nxt = num[AW+1] ? AW'(-num) : AW'(num);
          state_nxt = ST_RHS;
        end
      end
      ST_RHS: begin
        mul_a = PW'({mag_r, {K_BITS{1'b0}}});
        mul_b = {mag_r, {K_BITS{1'b0}}};
        if (mul_done) begin
          rhs_nxt = mul_prod;
          state_nxt = ST_AB;
        end
      end
      ST_AB: begin
        mul_a = PW'(spa_r);
        mul_b = BW'(spb_r);
        if (mul_done) begin
          ab_nxt = mul_prod;
          k_nxt = '0;
          bit_nxt = IW'(K_BITS - 1);
          state_nxt = ST_TRY;
        end
      end
      ST_TRY: begin
        if (cand > K_BITS'(ONE_FIXED)) begin
          if (bit_r == '0) begin
            res_corr_nxt = neg_r ? -CORR_BITS'(k_r) : CORR_BITS'(k_r);
            state_nxt = ST_OUT;
          end else begin
            bit_nxt = bit_r - IW'(1);
          end
        end else begin
          state_nxt = ST_ODD2;
        end
      end
      ST_ODD2: begin
        mul_a = PW'(odd);
        mul_b = BW'(odd);
        if (mul_done) begin
          odd2_nxt = (2*K_BITS)'(mul_prod);
          state_nxt = ST_LHS;
        end
      end
      ST_LHS: begin
        mul_a = ab_r;
        mul_b = BW'(odd2_r);
        if (mul_done) begin
          if (mul_prod <= rhs_r) k_nxt = cand;
          if (bit_r == '0) begin
            res_corr_nxt = neg_r ? -CORR_BITS'((mul_prod <= rhs_r) ? cand : k_r)
                                 : CORR_BITS'((mul_prod <= rhs_r) ? cand : k_r);
            state_nxt = ST_OUT;
          end else begin
            bit_nxt = bit_r - IW'(1);
            state_nxt = ST_TRY;
          end
        end
      end
      ST_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          corr_nxt = res_corr_r;
          degen_nxt = res_degen_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    mul_start = 1'b0;
    case (state_r)
      ST_NXX, ST_SX2, ST_NYY, ST_SY2, ST_P, ST_Q, ST_RHS, ST_AB, ST_ODD2, ST_LHS: begin
        if (!started_r) begin
          mul_start = 1'b1;
          started_nxt = 1'b1;
        end else if (mul_done) begin
          started_nxt = 1'b0;
        end
      end
      default: started_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      started_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    sx_r <= sx_nxt;
    sy_r <= sy_nxt;
    sxx_r <= sxx_nxt;
    syy_r <= syy_nxt;
    sxy_r <= sxy_nxt;
    tmp_r <= tmp_nxt;
    rhs_r <= rhs_nxt;
    ab_r <= ab_nxt;
    spa_r <= spa_nxt;
    spb_r <= spb_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    k_r <= k_nxt;
    bit_r <= bit_nxt;
    odd2_r <= odd2_nxt;
    corr_r <= corr_nxt;
    degen_r <= degen_nxt;
    res_corr_r <= res_corr_nxt;
    res_degen_r <= res_degen_nxt;
  end
endmodule
`default_nettype wire

[dv/tb_pearson_correlation_column.sv]
// testbench for the pearson correlation column block
`default_nettype none
module tb_pearson_correlation_column;
  import pcc_pkg::*;

  localparam int MAX_PAIRS = 4096;
  localparam int SAMPLE_BITS = 16;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } pair_t;

  typedef struct {
    logic [CORR_BITS-1:0] corr;
    logic                 degen;
  } corr_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [SAMPLE_BITS-1:0] in_x_sample = '0;
  logic [SAMPLE_BITS-1:0] in_y_sample = '0;
  logic in_last_of_column = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [CORR_BITS-1:0] out_correlation;
  logic out_degenerate;

  pair_t pending_pairs[$];
  corr_t expected_corrs[$];
  int errors = 0;
  int columns_checked = 0;
  int degenerate_seen = 0;
  bit hold_off = 0;
  int send_gap = 0;
  int recv_gap = 0;

  // running sums of the column model
  longint unsigned n_pairs;
  longint sx, sy, sxy;
  longint unsigned sxx, syy;

  pearson_correlation_column #(.MAX_PAIRS(MAX_PAIRS), .SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x_sample(in_x_sample), .in_y_sample(in_y_sample),
    .in_last_of_column(in_last_of_column),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_correlation(out_correlation), .out_degenerate(out_degenerate)
  );

  always #6 clk = ~clk;

  function automatic logic [255:0] mag_of(longint v);
    return v < 0 ? 256'(-v) : 256'(v);
  endfunction

  // accumulate one pair and on the last one compute the rounded coefficient
  function automatic void correlate_pair(pair_t p);
    longint x, y;
    logic [255:0] nn, a, b, pp, q, pos, neg, mag, m, rhs, ab, lhs;
    logic q_neg, negative;
    longint unsigned lo, hi, mid;
    corr_t r;
    if (n_pairs < MAX_PAIRS) begin
      x = longint'($signed(p.x));
      y = longint'($signed(p.y));
      n_pairs++;
      sx += x;
      sy += y;
      sxx += longint'(x * x);
      syy += longint'(y * y);
      sxy += x * y;
    end
    if (!p.last) return;
    nn = 256'(n_pairs);
    a = nn * 256'(sxx) - mag_of(sx) * mag_of(sx);
    b = nn * 256'(syy) - mag_of(sy) * mag_of(sy);
    r.corr = '0;
    r.degen = 0;
    if (a == 0 || b == 0) begin
      r.degen = 1;
    end else begin
      pp = nn * mag_of(sxy);
      q = mag_of(sx) * mag_of(sy);
      q_neg = (sx < 0) != (sy < 0);
      pos = (sxy >= 0 ? pp : 256'(0)) + (q_neg ? q : 256'(0));
      neg = (sxy < 0 ? pp : 256'(0)) + (q_neg ? 256'(0) : q);
      negative = pos < neg;
      mag = negative ? neg - pos : pos - neg;
      m = mag * 256'(2 * ONE_FIXED);
      rhs = m * m;
      ab = a * b;
      lo = 0;
      hi = ONE_FIXED;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 256'((2 * mid - 1) * (2 * mid - 1)) * ab;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      r.corr = negative ? CORR_BITS'(-longint'(lo)) : CORR_BITS'(lo);
    end
    expected_corrs.push_back(r);
    n_pairs = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        correlate_pair('{in_x_sample, in_y_sample, in_last_of_column});
        send_gap <= $urandom_range(0, 9) * $urandom_range(0, 1);
      end
      if ((in_valid && !in_stall) || !in_valid) begin
        if (send_gap == 0 && pending_pairs.size() > 0) begin
          in_x_sample <= pending_pairs[0].x;
          in_y_sample <= pending_pairs[0].y;
          in_last_of_column <= pending_pairs[0].last;
          in_valid <= 1;
          void'(pending_pairs.pop_front());
        end else begin
          in_valid <= 0;
          if (send_gap > 0 && !(in_valid && !in_stall)) send_gap <= send_gap - 1;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_corrs.size() == 0) begin
          report_mismatch("unexpected result", $signed(out_correlation), 0);
        end else begin
          if (out_correlation !== expected_corrs[0].corr)
            report_mismatch("correlation", $signed(out_correlation),
                            $signed(expected_corrs[0].corr));
          if (out_degenerate !== expected_corrs[0].degen)
            report_mismatch("degenerate", out_degenerate, expected_corrs[0].degen);
          if (expected_corrs[0].degen) degenerate_seen++;
          void'(expected_corrs.pop_front());
          columns_checked++;
        end
        recv_gap <= $urandom_range(0, 9) * $urandom_range(0, 1);
        out_stall <= hold_off || recv_gap != 0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1;
      end else begin
        out_stall <= hold_off;
      end
    end
  end

  // long receiver hold-off so the snapshot queue fills and the input stalls
  initial begin
    wait (rst_n);
    repeat (3000) @(posedge clk);
    hold_off <= 1;
    repeat (20000) @(posedge clk);
    hold_off <= 0;
  end

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_column(int len, int style);
    pair_t p;
    logic [15:0] cx, cy;
    logic [15:0] slope;
    cx = rand_sample();
    cy = rand_sample();
    slope = 16'($urandom_range(0, 3));
    for (int i = 0; i < len; i++) begin
      p.x = rand_sample();
      p.y = rand_sample();
      case (style)
        1: p.x = cx;
        2: p.y = cy;
        3: p.y = p.x;
        4: p.y = -p.x;
        5: begin p.x = 16'($urandom_range(0, 200)); p.y = p.x * slope + 16'($urandom_range(0, 40)); end
        default: ;
      endcase
      p.last = (i == len - 1);
      pending_pairs.push_back(p);
    end
  endtask

  initial begin
    int total;
    n_pairs = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // directed columns: single pair, constants, extremes, perfect correlation
    pending_pairs.push_back('{16'h7fff, 16'h8000, 1'b1});
    pending_pairs.push_back('{16'h8000, 16'h7fff, 1'b0});
    pending_pairs.push_back('{16'h7fff, 16'h8000, 1'b1});
    pending_pairs.push_back('{16'h8000, 16'h8000, 1'b0});
    pending_pairs.push_back('{16'h7fff, 16'h7fff, 1'b0});
    pending_pairs.push_back('{16'h0000, 16'hffff, 1'b1});
    add_column(4, 1);
    add_column(4, 2);
    add_column(5, 3);
    add_column(5, 4);
    total = 24;
    while (total < 1120) begin
      int len, style;
      len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
      style = $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 5);
      add_column(len, style);
      total += len;
    end
    add_column(6, 0);
    wait (pending_pairs.size() == 0 && !in_valid);
    wait (expected_corrs.size() == 0);
    repeat (3000) @(posedge clk);
    $display("checked %0d column results, %0d of them degenerate,", columns_checked,
             degenerate_seen);
    $display("with random gaps on both sides and one long output hold-off");
    if (errors == 0 && expected_corrs.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #100000000;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
